>>> rtl/core/dss_pkg.sv
// Package for the divisor-sum block: widths, sequencer states.
// No dependencies.
`default_nettype none
package dss_pkg;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 36;
    localparam int EXCESS_W = 37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_MUL,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/divisor_sum_sigma_top.sv
// Top level of the divisor-sum block: sequencer around one shared divider.
// Depends on dss_pkg and dss_divider.
`default_nettype none
// Computes sigma(value) and sigma(value) - 2*value by trial division: 2, then
// odd candidates d while d <= rest/d. Every trial is one pass of a shared
// restoring divider: a start state, one divide step per quotient bit and a
// decision in the wait state. Each prime factor divided out adds a shift-add
// multiply-accumulate, and a prime cofactor left at the end adds one more. A
// prime near 2^32 tries about 32800 candidates. One request is worked at a
// time; s_ready is low from the accept until the result is taken. Sums of
// 32-bit values always fit in 36 bits.
module divisor_sum_sigma_top #(
    parameter int VALUE_WIDTH = dss_pkg::VALUE_W
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dss_pkg::VALUE_W-1:0]     s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dss_pkg::SUM_W-1:0]            m_divisor_sum,
    output logic signed [dss_pkg::EXCESS_W-1:0]  m_excess
);
    import dss_pkg::*;

    localparam int NW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] n_reg, n_next;
    logic [VALUE_W-1:0] rest_reg, rest_next;
    logic [VALUE_W-1:0] d_reg, d_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;       // product of finished prime terms
    logic [SUM_W-1:0]   acc_reg, acc_next;       // multiply-accumulate result
    logic [SUM_W-1:0]   mcand_reg, mcand_next;
    logic [VALUE_W-1:0] mplier_reg, mplier_next;
    logic               strip_reg, strip_next;   // 1: stripping prime d
    logic               tail_reg, tail_next;     // 1: multiply for leftover prime
    logic               div_start;
    logic               div_busy;
    logic [VALUE_W-1:0] quo, rem;
    logic [VALUE_W-1:0] s_masked;
    logic               loop_exit;
    logic               divides;
    logic               mul_done;

    assign s_masked = s_value & VALUE_W'((64'd1 << NW) - 64'd1);

    dss_divider #(.WIDTH(VALUE_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // Decode the finished division and multiply
    assign loop_exit = !strip_reg && (d_reg != VALUE_W'(2)) && (d_reg > quo);
    assign divides   = (rem == '0);
    assign mul_done  = (mplier_reg == '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_masked <= VALUE_W'(1)) state_next = ST_DONE;
                    else state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (!div_busy) begin
                    if (loop_exit) begin
                        if (rest_reg > VALUE_W'(1)) state_next = ST_MUL;
                        else state_next = ST_DONE;
                    end else if (divides) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    if (tail_reg) state_next = ST_DONE;
                    else state_next = ST_DIV;
                end
            end
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and divider control
    always_comb begin
        n_next      = n_reg;
        rest_next   = rest_reg;
        d_next      = d_reg;
        sum_next    = sum_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        strip_next  = strip_reg;
        tail_next   = tail_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Load the request; zero and one finish at once
                if (s_valid) begin
                    n_next     = s_masked;
                    rest_next  = s_masked;
                    d_next     = VALUE_W'(2);
                    sum_next   = (s_masked == '0) ? '0 : SUM_W'(1);
                    strip_next = 1'b0;
                    tail_next  = 1'b0;
                end
            end
            ST_DIV: div_start = 1'b1;
            ST_WAIT: begin
                if (!div_busy) begin
                    if (loop_exit) begin
                        // Leftover cofactor is prime: sum * rest + sum
                        acc_next    = sum_reg;
                        mcand_next  = sum_reg;
                        mplier_next = rest_reg;
                        tail_next   = 1'b1;
                    end else if (divides) begin
                        // Divide d out; prime term by Horner: acc * d + sum
                        rest_next   = quo;
                        acc_next    = sum_reg;
                        mcand_next  = strip_reg ? acc_reg : sum_reg;
                        mplier_next = d_reg;
                    end else begin
                        // Close the prime term and advance the candidate
                        if (strip_reg) sum_next = acc_reg;
                        strip_next = 1'b0;
                        d_next     = (d_reg == VALUE_W'(2)) ? VALUE_W'(3)
                                                            : d_reg + VALUE_W'(2);
                    end
                end
            end
            ST_MUL: begin
                // Shift-add one multiplier bit per cycle
                if (mul_done) begin
                    if (tail_reg) sum_next = acc_reg;
                    strip_next = 1'b1;
                end else begin
                    if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
                    mcand_next  = {mcand_reg[SUM_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[VALUE_W-1:1]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg      <= n_next;
        rest_reg   <= rest_next;
        d_reg      <= d_next;
        sum_reg    <= sum_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        strip_reg  <= strip_next;
        tail_reg   <= tail_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_DONE);
    assign m_divisor_sum = sum_reg;
    assign m_excess      = $signed(EXCESS_W'({1'b0, sum_reg}) - EXCESS_W'({n_reg, 1'b0}));

`ifndef NO_ASSERTIONS
    // Result never shows while a request is being taken
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid overlap");
    // A unit request finishes with sum one
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && n_reg == VALUE_W'(1)) |-> sum_reg == SUM_W'(1))
        else $error("sigma(1) wrong");
    // Divider is idle whenever a result is offered
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !div_busy) else $error("divider busy at result");
    // Hold a stalled result unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_divisor_sum) && $stable(m_excess)))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

>>> rtl/core/dss_divider.sv
// Restoring divider, one quotient bit per cycle.
// Does not depend on dss_pkg; standalone.
`default_nettype none
module dss_divider #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  busy,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WIDTH:0]   trial;

    // Shift in one dividend bit and try a subtract
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[WIDTH-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = WIDTH'(trial - {1'b0, d_reg});
                q_next = {q_reg[WIDTH-2:0], 1'b1};
            end else begin
                r_next = trial[WIDTH-1:0];
                q_next = {q_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire
